// ===== design/point_rotation_by_degrees_core_macros.svh =====
// ----------------------------------------------------------------------------
// Point rotation assertion macros
// Concurrent check wrappers shared by the rotation core modules.
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATION_BY_DEGREES_CORE_MACROS_SVH
`define POINT_ROTATION_BY_DEGREES_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define PRBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prbd: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define PRBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prbd: next-cycle check failed");
`else
`define PRBD_ASSERT_SAME(label, clk, rst, ante, cons)
`define PRBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/prbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point rotation package
// Pipeline stage map, trig format, angle constants and the sine quarter table.
// ----------------------------------------------------------------------------
package prbd_pkg;

   // Trig format: Q1.TRIG_FRAC_BITS, one extra bit for sign
   localparam int TRIG_FRAC_BITS = 14;
   localparam int TRIG_BITS      = TRIG_FRAC_BITS + 2;
   localparam int TRIG_MAG_BITS  = TRIG_FRAC_BITS + 1;

   // Angle register and reduced angle
   localparam int ANGLE_BITS      = 10;
   localparam int ANGLE_WIDE_BITS = ANGLE_BITS + 1;
   localparam int DEG_BITS        = 9;
   localparam int QIDX_BITS       = 7;
   localparam int DEG_QUARTER     = 90;
   localparam int DEG_HALF        = 180;
   localparam int DEG_THREE_Q     = 270;
   localparam int DEG_FULL        = 360;

   // Pipeline stages
   localparam int PIPE_STAGES = 5;
   localparam int ST_ANGLE    = 0;
   localparam int ST_INDEX    = 1;
   localparam int ST_TRIG     = 2;
   localparam int ST_MULT     = 3;
   localparam int ST_SUM      = 4;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quadrant_type;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] load;
      logic [PIPE_STAGES-1:0] valid;
   } prbd_ctrl_type;

   // Sine of 0..90 whole degrees, rounded to nearest Q1.14
   function automatic logic [TRIG_MAG_BITS-1:0] quarter_sine(input logic [QIDX_BITS-1:0] idx);
      logic [TRIG_MAG_BITS-1:0] val;
      case (idx)
         7'd0:  val = 15'd0;
         7'd1:  val = 15'd286;
         7'd2:  val = 15'd572;
         7'd3:  val = 15'd857;
         7'd4:  val = 15'd1143;
         7'd5:  val = 15'd1428;
         7'd6:  val = 15'd1713;
         7'd7:  val = 15'd1997;
         7'd8:  val = 15'd2280;
         7'd9:  val = 15'd2563;
         7'd10: val = 15'd2845;
         7'd11: val = 15'd3126;
         7'd12: val = 15'd3406;
         7'd13: val = 15'd3686;
         7'd14: val = 15'd3964;
         7'd15: val = 15'd4240;
         7'd16: val = 15'd4516;
         7'd17: val = 15'd4790;
         7'd18: val = 15'd5063;
         7'd19: val = 15'd5334;
         7'd20: val = 15'd5604;
         7'd21: val = 15'd5872;
         7'd22: val = 15'd6138;
         7'd23: val = 15'd6402;
         7'd24: val = 15'd6664;
         7'd25: val = 15'd6924;
         7'd26: val = 15'd7182;
         7'd27: val = 15'd7438;
         7'd28: val = 15'd7692;
         7'd29: val = 15'd7943;
         7'd30: val = 15'd8192;
         7'd31: val = 15'd8438;
         7'd32: val = 15'd8682;
         7'd33: val = 15'd8923;
         7'd34: val = 15'd9162;
         7'd35: val = 15'd9397;
         7'd36: val = 15'd9630;
         7'd37: val = 15'd9860;
         7'd38: val = 15'd10087;
         7'd39: val = 15'd10311;
         7'd40: val = 15'd10531;
         7'd41: val = 15'd10749;
         7'd42: val = 15'd10963;
         7'd43: val = 15'd11174;
         7'd44: val = 15'd11381;
         7'd45: val = 15'd11585;
         7'd46: val = 15'd11786;
         7'd47: val = 15'd11982;
         7'd48: val = 15'd12176;
         7'd49: val = 15'd12365;
         7'd50: val = 15'd12551;
         7'd51: val = 15'd12733;
         7'd52: val = 15'd12911;
         7'd53: val = 15'd13085;
         7'd54: val = 15'd13255;
         7'd55: val = 15'd13421;
         7'd56: val = 15'd13583;
         7'd57: val = 15'd13741;
         7'd58: val = 15'd13894;
         7'd59: val = 15'd14044;
         7'd60: val = 15'd14189;
         7'd61: val = 15'd14330;
         7'd62: val = 15'd14466;
         7'd63: val = 15'd14598;
         7'd64: val = 15'd14726;
         7'd65: val = 15'd14849;
         7'd66: val = 15'd14968;
         7'd67: val = 15'd15082;
         7'd68: val = 15'd15191;
         7'd69: val = 15'd15296;
         7'd70: val = 15'd15396;
         7'd71: val = 15'd15491;
         7'd72: val = 15'd15582;
         7'd73: val = 15'd15668;
         7'd74: val = 15'd15749;
         7'd75: val = 15'd15826;
         7'd76: val = 15'd15897;
         7'd77: val = 15'd15964;
         7'd78: val = 15'd16026;
         7'd79: val = 15'd16083;
         7'd80: val = 15'd16135;
         7'd81: val = 15'd16182;
         7'd82: val = 15'd16224;
         7'd83: val = 15'd16262;
         7'd84: val = 15'd16294;
         7'd85: val = 15'd16322;
         7'd86: val = 15'd16344;
         7'd87: val = 15'd16362;
         7'd88: val = 15'd16374;
         7'd89: val = 15'd16382;
         7'd90: val = 15'd16384;
         default: val = 15'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== design/prbd_flow.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point rotation pipeline flow control
// Valid bits per stage with bubble collapse; produces per-stage load enables.
// ----------------------------------------------------------------------------
`include "point_rotation_by_degrees_core_macros.svh"
module prbd_flow
   import prbd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output prbd_ctrl_type ctrl
);

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] stage_rdy;
   logic [PIPE_STAGES-1:0] feed;

   // Ready ripples back from the output; an empty stage always takes a beat
   always_comb begin
      stage_rdy[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
      feed[0] = req_tvalid;
      for (int i = 1; i < PIPE_STAGES; i++) begin
         feed[i] = valid_ff[i-1];
      end
      for (int i = 0; i < PIPE_STAGES; i++) begin
         valid_in[i] = stage_rdy[i] ? feed[i] : valid_ff[i];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load  = stage_rdy & feed;
   assign ctrl.valid = valid_ff;
   assign req_tready = stage_rdy[ST_ANGLE];
   assign rsp_tvalid = valid_ff[ST_SUM];

   // An accepted beat occupies the first stage next cycle
   `PRBD_ASSERT_NEXT(a_accept_fills, clock, reset, req_tvalid && req_tready, valid_ff[ST_ANGLE])
   // Input stalls only when every stage holds a beat
   `PRBD_ASSERT_SAME(a_stall_only_full, clock, reset, !req_tready, &valid_ff)
   // Output drained with nothing behind it leaves the output empty
   `PRBD_ASSERT_NEXT(a_drain_empty, clock, reset,
      rsp_tvalid && rsp_tready && !valid_ff[ST_MULT], !rsp_tvalid)

endmodule

// ===== design/prbd_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point rotation trig path
// Angle register, reduction to 0..359, quadrant split and sine/cosine lookup.
// ----------------------------------------------------------------------------
`include "point_rotation_by_degrees_core_macros.svh"
module prbd_trig
   import prbd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic signed [ANGLE_BITS-1:0] csr_wr_data,
   input  prbd_ctrl_type               ctrl,
   output logic signed [TRIG_BITS-1:0] sin_val,
   output logic signed [TRIG_BITS-1:0] cos_val
);

   logic signed [ANGLE_BITS-1:0]      angle_ff;
   logic signed [ANGLE_WIDE_BITS-1:0] angle_wide;
   logic signed [ANGLE_WIDE_BITS-1:0] angle_red;
   logic [DEG_BITS-1:0]               deg_ff;
   logic [DEG_BITS-1:0]               deg_in;
   quadrant_type                      quad;
   logic [DEG_BITS-1:0]               rem_wide;
   logic [QIDX_BITS-1:0]              rem;
   logic [QIDX_BITS-1:0]              rem_rev;
   logic [QIDX_BITS-1:0]              sin_idx_ff;
   logic [QIDX_BITS-1:0]              sin_idx_in;
   logic [QIDX_BITS-1:0]              cos_idx_ff;
   logic [QIDX_BITS-1:0]              cos_idx_in;
   logic                              sin_neg_ff;
   logic                              sin_neg_in;
   logic                              cos_neg_ff;
   logic                              cos_neg_in;
   logic [TRIG_MAG_BITS-1:0]          sin_mag;
   logic [TRIG_MAG_BITS-1:0]          cos_mag;
   logic signed [TRIG_BITS-1:0]       sin_ff;
   logic signed [TRIG_BITS-1:0]       sin_in;
   logic signed [TRIG_BITS-1:0]       cos_ff;
   logic signed [TRIG_BITS-1:0]       cos_in;

   // Hold the angle register
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
      end else if (csr_wr_en) begin
         angle_ff <= csr_wr_data;
      end
   end

   // Reduce the signed angle modulo 360
   always_comb begin
      angle_wide = ANGLE_WIDE_BITS'(angle_ff);
      if (angle_wide < -ANGLE_WIDE_BITS'(DEG_FULL)) begin
         angle_red = angle_wide + ANGLE_WIDE_BITS'(2 * DEG_FULL);
      end else if (angle_wide < 0) begin
         angle_red = angle_wide + ANGLE_WIDE_BITS'(DEG_FULL);
      end else if (angle_wide >= ANGLE_WIDE_BITS'(DEG_FULL)) begin
         angle_red = angle_wide - ANGLE_WIDE_BITS'(DEG_FULL);
      end else begin
         angle_red = angle_wide;
      end
      deg_in = angle_red[DEG_BITS-1:0];
   end

   // Split into quadrant and offset, pick table indexes and signs
   always_comb begin
      if (deg_ff >= DEG_BITS'(DEG_THREE_Q)) begin
         quad     = QUAD_FOURTH;
         rem_wide = deg_ff - DEG_BITS'(DEG_THREE_Q);
      end else if (deg_ff >= DEG_BITS'(DEG_HALF)) begin
         quad     = QUAD_THIRD;
         rem_wide = deg_ff - DEG_BITS'(DEG_HALF);
      end else if (deg_ff >= DEG_BITS'(DEG_QUARTER)) begin
         quad     = QUAD_SECOND;
         rem_wide = deg_ff - DEG_BITS'(DEG_QUARTER);
      end else begin
         quad     = QUAD_FIRST;
         rem_wide = deg_ff;
      end
      rem     = rem_wide[QIDX_BITS-1:0];
      rem_rev = QIDX_BITS'(DEG_QUARTER) - rem;
      case (quad)
         QUAD_FIRST: begin
            sin_idx_in = rem;
            cos_idx_in = rem_rev;
            sin_neg_in = 1'b0;
            cos_neg_in = 1'b0;
         end
         QUAD_SECOND: begin
            sin_idx_in = rem_rev;
            cos_idx_in = rem;
            sin_neg_in = 1'b0;
            cos_neg_in = 1'b1;
         end
         QUAD_THIRD: begin
            sin_idx_in = rem;
            cos_idx_in = rem_rev;
            sin_neg_in = 1'b1;
            cos_neg_in = 1'b1;
         end
         QUAD_FOURTH: begin
            sin_idx_in = rem_rev;
            cos_idx_in = rem;
            sin_neg_in = 1'b1;
            cos_neg_in = 1'b0;
         end
         default: begin
            sin_idx_in = rem;
            cos_idx_in = rem_rev;
            sin_neg_in = 1'b0;
            cos_neg_in = 1'b0;
         end
      endcase
   end

   // Look up magnitudes and apply signs
   always_comb begin
      sin_mag = quarter_sine(sin_idx_ff);
      cos_mag = quarter_sine(cos_idx_ff);
      sin_in  = sin_neg_ff ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      cos_in  = cos_neg_ff ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
   end

   // Advance the trig stages
   always_ff @(posedge clock) begin
      if (ctrl.load[ST_ANGLE]) begin
         deg_ff <= deg_in;
      end
      if (ctrl.load[ST_INDEX]) begin
         sin_idx_ff <= sin_idx_in;
         cos_idx_ff <= cos_idx_in;
         sin_neg_ff <= sin_neg_in;
         cos_neg_ff <= cos_neg_in;
      end
      if (ctrl.load[ST_TRIG]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

   // Sine and cosine indexes are complementary within a quadrant
   `PRBD_ASSERT_SAME(a_idx_complement, clock, reset, ctrl.valid[ST_INDEX],
      ({1'b0, sin_idx_ff} + {1'b0, cos_idx_ff}) == 8'(DEG_QUARTER))

endmodule

// ===== design/prbd_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point rotation multiply-add path
// Carries the point alongside the trig path, forms four products, then sums.
// ----------------------------------------------------------------------------
module prbd_mult
   import prbd_pkg::*;
#(
   parameter int COORD_BITS = 16,
   localparam int OUT_BITS  = COORD_BITS + TRIG_FRAC_BITS + 1
) (
   input  logic                         clock,
   input  prbd_ctrl_type                ctrl,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic                         last_point,
   input  logic signed [TRIG_BITS-1:0]  sin_val,
   input  logic signed [TRIG_BITS-1:0]  cos_val,
   output logic signed [OUT_BITS-1:0]   rotated_x,
   output logic signed [OUT_BITS-1:0]   rotated_y,
   output logic                         last_point_out
);

   localparam int PROD_BITS = COORD_BITS + TRIG_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   logic signed [COORD_BITS-1:0] x_ff    [ST_ANGLE:ST_TRIG];
   logic signed [COORD_BITS-1:0] y_ff    [ST_ANGLE:ST_TRIG];
   logic                         last_ff [ST_ANGLE:ST_SUM];
   logic signed [PROD_BITS-1:0]  xc_ff;
   logic signed [PROD_BITS-1:0]  ys_ff;
   logic signed [PROD_BITS-1:0]  xs_ff;
   logic signed [PROD_BITS-1:0]  yc_ff;
   logic signed [SUM_BITS-1:0]   rx_sum;
   logic signed [SUM_BITS-1:0]   ry_sum;
   logic signed [OUT_BITS-1:0]   rx_ff;
   logic signed [OUT_BITS-1:0]   ry_ff;

   // Exact sums; the result always fits the output width
   assign rx_sum = SUM_BITS'(xc_ff) - SUM_BITS'(ys_ff);
   assign ry_sum = SUM_BITS'(xs_ff) + SUM_BITS'(yc_ff);

   // Carry the point while the trig path works, then multiply and sum
   always_ff @(posedge clock) begin
      if (ctrl.load[ST_ANGLE]) begin
         x_ff[ST_ANGLE]    <= point_x;
         y_ff[ST_ANGLE]    <= point_y;
         last_ff[ST_ANGLE] <= last_point;
      end
      if (ctrl.load[ST_INDEX]) begin
         x_ff[ST_INDEX]    <= x_ff[ST_ANGLE];
         y_ff[ST_INDEX]    <= y_ff[ST_ANGLE];
         last_ff[ST_INDEX] <= last_ff[ST_ANGLE];
      end
      if (ctrl.load[ST_TRIG]) begin
         x_ff[ST_TRIG]    <= x_ff[ST_INDEX];
         y_ff[ST_TRIG]    <= y_ff[ST_INDEX];
         last_ff[ST_TRIG] <= last_ff[ST_INDEX];
      end
      if (ctrl.load[ST_MULT]) begin
         xc_ff            <= x_ff[ST_TRIG] * cos_val;
         ys_ff            <= y_ff[ST_TRIG] * sin_val;
         xs_ff            <= x_ff[ST_TRIG] * sin_val;
         yc_ff            <= y_ff[ST_TRIG] * cos_val;
         last_ff[ST_MULT] <= last_ff[ST_TRIG];
      end
      if (ctrl.load[ST_SUM]) begin
         rx_ff           <= rx_sum[OUT_BITS-1:0];
         ry_ff           <= ry_sum[OUT_BITS-1:0];
         last_ff[ST_SUM] <= last_ff[ST_MULT];
      end
   end

   assign rotated_x      = rx_ff;
   assign rotated_y      = ry_ff;
   assign last_point_out = last_ff[ST_SUM];

endmodule

// ===== design/point_rotation_by_degrees_core.sv =====
`timescale 1ns / 1ps
// Throughput: one point per cycle while rsp_tready is high; an accepted
// request beat passes in order through five register stages (angle reduce,
// quadrant split, table lookup, multiply, add) to its response beat.
// A stalled output holds its beat; empty stages upstream still accept.
// Reset: synchronous, active high; clears all stage valid bits and sets the
// rotation angle to 0 degrees.
// ----------------------------------------------------------------------------
// Point rotation core
// Rotates a stream of 2D integer points by a whole-degree angle, Q.14 output.
// ----------------------------------------------------------------------------
module point_rotation_by_degrees_core
   import prbd_pkg::*;
#(
   parameter int COORD_BITS       = 16,
   localparam int OUT_BITS        = COORD_BITS + TRIG_FRAC_BITS + 1,
   localparam int REQ_TDATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_TDATA_BITS  = ((2 * OUT_BITS + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_TDATA_BITS-1:0]    req_tdata,   // point_x, point_y, zero pad
   input  logic                         req_tlast,   // last_point
   // Response stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]    rsp_tdata,   // rotated_x, rotated_y, zero pad
   output logic                         rsp_tlast,   // last_point_out
   // Angle register
   input  logic                         csr_wr_en,
   input  logic signed [ANGLE_BITS-1:0] csr_wr_data
);

   prbd_ctrl_type                ctrl;
   logic signed [TRIG_BITS-1:0]  sin_val;
   logic signed [TRIG_BITS-1:0]  cos_val;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [OUT_BITS-1:0]   rotated_x;
   logic signed [OUT_BITS-1:0]   rotated_y;

   // Unpack request beat
   assign point_x = req_tdata[COORD_BITS-1:0];
   assign point_y = req_tdata[2*COORD_BITS-1:COORD_BITS];

   prbd_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   prbd_trig u_trig (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctrl        (ctrl),
      .sin_val     (sin_val),
      .cos_val     (cos_val)
   );

   prbd_mult #(
      .COORD_BITS (COORD_BITS)
   ) u_mult (
      .clock          (clock),
      .ctrl           (ctrl),
      .point_x        (point_x),
      .point_y        (point_y),
      .last_point     (req_tlast),
      .sin_val        (sin_val),
      .cos_val        (cos_val),
      .rotated_x      (rotated_x),
      .rotated_y      (rotated_y),
      .last_point_out (rsp_tlast)
   );

   // Pack response beat
   assign rsp_tdata = RSP_TDATA_BITS'({rotated_y, rotated_x});

endmodule
